// File: src/pols_pkg.sv
// Package for the positional ordered list store.
// Holds operation codes, status codes, cell commands and the cell command struct.
// No dependencies.
package pols_pkg;

  // Operation codes carried by the action field
  localparam logic [3:0] ACT_ADD_FRONT = 4'd0;
  localparam logic [3:0] ACT_ADD_BACK  = 4'd1;
  localparam logic [3:0] ACT_DEL_FIRST = 4'd2;
  localparam logic [3:0] ACT_DEL_LAST  = 4'd3;
  localparam logic [3:0] ACT_INSERT_AT = 4'd4;
  localparam logic [3:0] ACT_DELETE_AT = 4'd5;
  localparam logic [3:0] ACT_FIND      = 4'd6;
  localparam logic [3:0] ACT_READ_AT   = 4'd7;
  localparam logic [3:0] ACT_LENGTH    = 4'd8;

  // Result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOOP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Command broadcast to every cell of the chain
  typedef logic [2:0] cell_op_t;
  localparam cell_op_t OP_NONE = 3'd0;
  localparam cell_op_t OP_INS  = 3'd1;
  localparam cell_op_t OP_DEL  = 3'd2;
  localparam cell_op_t OP_FIND = 3'd3;
  localparam cell_op_t OP_READ = 3'd4;

  typedef struct packed {
    cell_op_t    op;
    logic [7:0]  pos;
    logic [31:0] val;
  } pols_cmd_t;

endpackage

// File: src/pols_in_if.sv
// Input channel interface of the positional ordered list store.
// Carries valid, ready and one operation; no dependencies.
interface pols_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         action;
  logic [7:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output action, output position, output value, input ready);
  modport sink   (input valid, input action, input position, input value, output ready);
endinterface

// File: src/pols_out_if.sv
// Result channel interface of the positional ordered list store.
// Carries valid, ready and one result; no dependencies.
interface pols_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               found;
  logic signed [31:0] data_out;
  logic [4:0]         length;

  modport source (output valid, output status, output found, output data_out, output length,
                  input ready);
  modport sink   (input valid, input status, input found, input data_out, input length,
                  output ready);
endinterface

// File: src/pols_cell.sv
// One cell of the list chain: holds the entry at a fixed position.
// Shifts with its neighbors on insert and delete and flags find and read hits.
// Depends on pols_pkg.
module pols_cell
  import pols_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic            clk,
  input  logic            load,
  input  pols_cmd_t       cmd,
  input  logic [CW-1:0]   count,
  input  logic [31:0]     left_entry,
  input  logic [31:0]     right_entry,
  output logic [31:0]     entry,
  output logic            hit,
  output logic [31:0]     hit_data
);

  localparam logic [7:0]    IDX_P = 8'(IDX);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [31:0] entry_r, entry_nxt;
  logic        hit_r, hit_nxt;
  logic [31:0] hit_data_r, hit_data_nxt;

  // Pick next entry: open a gap on insert, close it on delete
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      OP_INS: begin
        if (IDX_P > cmd.pos) begin
          entry_nxt = left_entry;
        end else if (IDX_P == cmd.pos) begin
          entry_nxt = cmd.val;
        end
      end
      OP_DEL: begin
        if (IDX_P >= cmd.pos) begin
          entry_nxt = right_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // Flag a match for find or the selected slot for read
  always_comb begin
    hit_nxt      = 1'b0;
    hit_data_nxt = '0;
    case (cmd.op)
      OP_FIND: begin
        hit_nxt = (entry_r == cmd.val) && (IDX_C < count);
      end
      OP_READ: begin
        if (IDX_P == cmd.pos) begin
          hit_nxt      = 1'b1;
          hit_data_nxt = entry_r;
        end
      end
      default: begin
        hit_nxt      = 1'b0;
        hit_data_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (load) begin
      hit_r      <= hit_nxt;
      hit_data_r <= hit_data_nxt;
    end
  end

  assign entry    = entry_r;
  assign hit      = hit_r;
  assign hit_data = hit_data_r;

endmodule

// File: src/positional_ordered_list_store.sv
// Positional ordered list store: holds up to DEPTH signed 32-bit values in a
// chain of cells, position 0 at the front. One operation is accepted per clock
// unless the result path stalls; inserts and deletes shift the cells from the
// target position on toward or from their neighbor in the accept cycle, and find
// compares all cells in parallel. Each operation yields exactly one result, through
// a compare stage and an output register that takes the cell-wide OR of the hit
// flags. Results leave in acceptance order.
// Depends on pols_pkg, pols_in_if, pols_out_if and pols_cell.
module positional_ordered_list_store
  import pols_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pols_in_if.sink     in_ch,
  pols_out_if.source  out_ch
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          s1_valid_r;
  logic [1:0]    s1_status_r;
  logic [4:0]    s1_len_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic          out_found_r;
  logic [31:0]   out_data_r;
  logic [4:0]    out_len_r;

  logic          s1_adv, s2_adv, accept;
  pols_cmd_t     dec_cmd, cell_cmd;
  logic [1:0]    dec_status;
  logic [8:0]    cnt9, pos9, tgt9, cnt_new9;

  logic [31:0]   cell_entry [DEPTH];
  logic          cell_hit   [DEPTH];
  logic [31:0]   cell_data  [DEPTH];
  logic          any_hit;
  logic [31:0]   any_data;

  // Stall control: stage 2 moves when the output is free, stage 1 behind it
  assign s2_adv      = !out_valid_r || out_ch.ready;
  assign s1_adv      = !s1_valid_r || s2_adv;
  assign in_ch.ready = s1_adv;
  assign accept      = in_ch.valid && s1_adv;

  // Decode the operation against the current length
  always_comb begin
    cnt9          = 9'(count_r);
    pos9          = {1'b0, in_ch.position};
    tgt9          = pos9;
    cnt_new9      = cnt9;
    dec_status    = ST_DONE;
    dec_cmd.op    = OP_NONE;
    dec_cmd.val   = in_ch.value;
    case (in_ch.action)
      ACT_ADD_FRONT, ACT_ADD_BACK, ACT_INSERT_AT: begin
        if (in_ch.action == ACT_ADD_FRONT) begin
          tgt9 = '0;
        end else if (in_ch.action == ACT_ADD_BACK) begin
          tgt9 = cnt9;
        end
        if (tgt9 > cnt9) begin
          dec_status = ST_NOOP;
        end else if (cnt9 >= 9'(DEPTH)) begin
          dec_status = ST_FULL;
        end else begin
          dec_cmd.op = OP_INS;
          cnt_new9   = cnt9 + 9'd1;
        end
      end
      ACT_DEL_FIRST, ACT_DEL_LAST, ACT_DELETE_AT: begin
        if (in_ch.action == ACT_DEL_FIRST) begin
          tgt9 = '0;
        end else if (in_ch.action == ACT_DEL_LAST) begin
          tgt9 = cnt9 - 9'd1;
        end
        if ((cnt9 == 9'd0) || (tgt9 >= cnt9)) begin
          dec_status = ST_NOOP;
        end else begin
          dec_cmd.op = OP_DEL;
          cnt_new9   = cnt9 - 9'd1;
        end
      end
      ACT_FIND: begin
        dec_cmd.op = OP_FIND;
      end
      ACT_READ_AT: begin
        if (pos9 < cnt9) begin
          dec_cmd.op = OP_READ;
        end else begin
          dec_status = ST_NOOP;
        end
      end
      ACT_LENGTH: begin
        dec_status = ST_DONE;
      end
      default: begin
        dec_status = ST_NOOP;
      end
    endcase
    dec_cmd.pos = tgt9[7:0];
  end

  // Drive the chain only for an accepted transaction
  always_comb begin
    cell_cmd = dec_cmd;
    if (!accept) begin
      cell_cmd.op = OP_NONE;
    end
  end

  assign count_nxt = accept ? CW'(cnt_new9) : count_r;

  // Build the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_e, right_e;
    if (i == 0) begin : g_first
      assign left_e = cell_entry[i];
    end else begin : g_mid_l
      assign left_e = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_e = cell_entry[i];
    end else begin : g_mid_r
      assign right_e = cell_entry[i+1];
    end
    pols_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .load        (accept),
      .cmd         (cell_cmd),
      .count       (count_r),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (cell_entry[i]),
      .hit         (cell_hit[i]),
      .hit_data    (cell_data[i])
    );
  end

  // Merge the registered hit flags of all cells
  always_comb begin
    any_hit  = 1'b0;
    any_data = '0;
    for (int k = 0; k < DEPTH; k++) begin
      any_hit  = any_hit | cell_hit[k];
      any_data = any_data | cell_data[k];
    end
  end

  // Stage 1: hold status and new length while the cells compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      s1_status_r <= dec_status;
      s1_len_r    <= cnt_new9[4:0];
    end
  end

  // Stage 2: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= s1_valid_r;
    end
    if (s2_adv && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_found_r  <= any_hit;
      out_data_r   <= any_data;
      out_len_r    <= s1_len_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.length   = out_len_r;

endmodule

// File: src/pols_checker.sv
// Port-level checks for the positional ordered list store, and their bind.
// Depends on pols_pkg and positional_ordered_list_store.
module pols_checker
  import pols_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_found,
  input logic [31:0] out_data_out,
  input logic [4:0]  out_length
);

  localparam logic [4:0] DEPTH_LEN = 5'(DEPTH);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_length)
      && $stable(out_data_out) && $stable(out_found))
    else $error("result changed while stalled");

  // A full rejection reports a full store
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_length == DEPTH_LEN)
    else $error("full status with store not full");

  // Found is only ever reported by a successful operation
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_DONE)
    else $error("found set on failed operation");

  // Read data comes only with a hit
  a_data_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data_out != 32'd0) |-> out_found)
    else $error("data without hit");

endmodule

bind positional_ordered_list_store pols_checker #(.DEPTH(DEPTH)) u_pols_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_found    (out_ch.found),
  .out_data_out (out_ch.data_out),
  .out_length   (out_ch.length)
);

// File: tb/pols_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the positional ordered list store: watches both channels,
// predicts each result from a shadow copy of the list and compares in order.
// Depends on pols_pkg, pols_in_if and pols_out_if.
module pols_scoreboard
  import pols_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  pols_in_if   in_mon,
  pols_out_if  out_mon,
  output int   error_count,
  output int   pending_count,
  output int   held_count
);

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] data_out;
    logic [4:0]         length;
  } list_result_t;

  logic signed [31:0] shadow_list[$];
  list_result_t       expected_results[$];
  int                 errors = 0;
  int                 result_idx = 0;

  assign error_count = errors;

  // Print one line per mismatch and count it
  task automatic report_error(input string msg);
    errors++;
    $display("[%0t] ERROR result %0d: %s", $time, result_idx, msg);
  endtask

  function automatic logic [1:0] insert_entry(input int pos, input logic signed [31:0] val);
    if (pos > shadow_list.size()) begin
      return ST_NOOP;
    end
    if (shadow_list.size() >= DEPTH) begin
      return ST_FULL;
    end
    shadow_list.insert(pos, val);
    return ST_DONE;
  endfunction

  function automatic logic [1:0] remove_entry(input int pos);
    if (pos >= shadow_list.size()) begin
      return ST_NOOP;
    end
    shadow_list.delete(pos);
    return ST_DONE;
  endfunction

  // Apply one operation to the shadow list and return the result it must produce
  function automatic list_result_t apply_list_op(input logic [3:0] act, input logic [7:0] pos,
                                                 input logic signed [31:0] val);
    list_result_t res;
    res = '{status: ST_DONE, found: 1'b0, data_out: '0, length: '0};
    case (act)
      ACT_ADD_FRONT: res.status = insert_entry(0, val);
      ACT_ADD_BACK:  res.status = insert_entry(shadow_list.size(), val);
      ACT_DEL_FIRST: res.status = remove_entry(0);
      ACT_DEL_LAST: begin
        if (shadow_list.size() == 0) res.status = ST_NOOP;
        else res.status = remove_entry(shadow_list.size() - 1);
      end
      ACT_INSERT_AT: res.status = insert_entry(int'(pos), val);
      ACT_DELETE_AT: res.status = remove_entry(int'(pos));
      ACT_FIND: begin
        foreach (shadow_list[i]) begin
          if (shadow_list[i] == val) res.found = 1'b1;
        end
      end
      ACT_READ_AT: begin
        if (int'(pos) < shadow_list.size()) begin
          res.found    = 1'b1;
          res.data_out = shadow_list[pos];
        end else begin
          res.status = ST_NOOP;
        end
      end
      ACT_LENGTH: ;
      default: res.status = ST_NOOP;
    endcase
    res.length = 5'(shadow_list.size());
    return res;
  endfunction

  // Check a finished transaction first, then queue the prediction for a new one,
  // so that a stray result can never match an operation taken in the same cycle
  always @(posedge clk) begin
    list_result_t got;
    list_result_t exp;
    if (!rst_n) begin
      shadow_list.delete();
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{status: out_mon.status, found: out_mon.found, data_out: out_mon.data_out,
                length: out_mon.length};
        if (expected_results.size() == 0) begin
          report_error("result with no operation outstanding");
        end else begin
          exp = expected_results.pop_front();
          if (got.status !== exp.status)
            report_error($sformatf("status got %0d expected %0d", got.status, exp.status));
          if (got.found !== exp.found)
            report_error($sformatf("found got %0b expected %0b", got.found, exp.found));
          if (got.data_out !== exp.data_out)
            report_error($sformatf("data_out got %0d expected %0d",
                                   got.data_out, exp.data_out));
          if (got.length !== exp.length)
            report_error($sformatf("length got %0d expected %0d", got.length, exp.length));
        end
        result_idx++;
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_results.push_back(apply_list_op(in_mon.action, in_mon.position,
                                                 in_mon.value));
      end
    end
    // Publish queue depths for the stimulus side
    pending_count = expected_results.size();
    held_count    = shadow_list.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the positional ordered list store testbench: clock, reset, operation
// stimulus with random idling on both channels, and the final verdict.
// Depends on pols_pkg, pols_in_if, pols_out_if, pols_scoreboard and the store.
module tb_top
  import pols_pkg::*;
();

  localparam int         DEPTH         = 16;
  localparam int         RANDOM_ITEMS  = 950;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam logic [3:0] ACT_UNUSED_LO = 4'd9;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on = 1'b1;
  int   cycle_count = 0;
  int   random_sent = 0;
  int   error_count;
  int   pending_count;
  int   held_count;

  pols_in_if  in_ch();
  pols_out_if out_ch();

  positional_ordered_list_store #(.DEPTH(DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pols_scoreboard #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .error_count   (error_count),
    .pending_count (pending_count),
    .held_count    (held_count)
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
      $display("** positional_ordered_list_store: FAILED **");
      $finish;
    end
  end

  // Stall the result channel at random while idling is enabled
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !(idle_on && $urandom_range(99) < 25);
    end
  end

  // Present one operation, maybe after a random gap, and hold it until accepted
  task automatic issue_op(input logic [3:0] act, input logic [7:0] pos, input logic [31:0] val);
    while (idle_on && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.position <= pos;
    in_ch.value    <= val;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Mostly small values so that finds hit, plus the extremes and full-range noise
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 32'($urandom_range(15)) - 32'd8;
    if (r < 60) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // Positions near the current length, sometimes anywhere in the field
  function automatic logic [7:0] pick_pos(input int len);
    if ($urandom_range(99) < 80) return 8'($urandom_range(len + 1));
    return 8'($urandom_range(255));
  endfunction

  task automatic issue_insert(input int pos_span);
    case ($urandom_range(2))
      0: issue_op(ACT_ADD_FRONT, pick_pos(held_count), pick_value());
      1: issue_op(ACT_ADD_BACK, pick_pos(held_count), pick_value());
      default: issue_op(ACT_INSERT_AT, 8'($urandom_range(pos_span)), pick_value());
    endcase
    random_sent++;
  endtask

  task automatic issue_delete(input int pos_span);
    case ($urandom_range(2))
      0: issue_op(ACT_DEL_FIRST, pick_pos(held_count), pick_value());
      1: issue_op(ACT_DEL_LAST, pick_pos(held_count), pick_value());
      default: issue_op(ACT_DELETE_AT, 8'($urandom_range(pos_span)), pick_value());
    endcase
    random_sent++;
  endtask

  task automatic issue_mixed();
    logic [3:0] act;
    if ($urandom_range(99) < 5) act = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    else act = 4'($urandom_range(ACT_LENGTH));
    issue_op(act, pick_pos(held_count), pick_value());
    random_sent++;
  endtask

  initial begin
    int kind;
    int extra;
    bit first_episode;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_LENGTH;
    in_ch.position = '0;
    in_ch.value    = '0;
    first_episode  = 1'b1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty store: every delete, read and positional insert is a no-op
    issue_op(ACT_LENGTH, 8'd0, 32'd0);
    issue_op(ACT_DEL_FIRST, 8'd0, 32'd0);
    issue_op(ACT_DEL_LAST, 8'd0, 32'd0);
    issue_op(ACT_DELETE_AT, 8'd0, 32'd0);
    issue_op(ACT_READ_AT, 8'd0, 32'd0);
    issue_op(ACT_FIND, 8'd0, 32'd0);
    issue_op(ACT_INSERT_AT, 8'd1, 32'd5);
    // Build a short list with the value extremes, inserting at front, middle and end
    issue_op(ACT_ADD_FRONT, 8'd0, 32'h8000_0000);
    issue_op(ACT_ADD_BACK, 8'hff, 32'h7fff_ffff);
    issue_op(ACT_INSERT_AT, 8'd1, 32'd0);
    issue_op(ACT_INSERT_AT, 8'd3, 32'hffff_ffff);
    issue_op(ACT_INSERT_AT, 8'hff, 32'd1);
    issue_op(ACT_READ_AT, 8'd3, 32'd0);
    issue_op(ACT_READ_AT, 8'd4, 32'd0);
    issue_op(ACT_FIND, 8'd0, 32'h8000_0000);
    issue_op(ACT_FIND, 8'd0, 32'h7fff_fffe);
    issue_op(ACT_DELETE_AT, 8'hff, 32'd0);
    issue_op(ACT_DELETE_AT, 8'd1, 32'd0);
    issue_op(ACT_UNUSED_LO, 8'hff, 32'hffff_ffff);
    issue_op(ACT_UNUSED_HI, 8'd0, 32'd0);
    issue_op(ACT_DEL_LAST, 8'd0, 32'd0);
    issue_op(ACT_DEL_FIRST, 8'd0, 32'd0);
    issue_op(ACT_LENGTH, 8'hff, 32'hffff_ffff);

    // Random episodes: fill to full and push past it, drain past empty, or mix
    while (random_sent < RANDOM_ITEMS) begin
      idle_on = !(random_sent >= 300 && random_sent < 500);
      kind = first_episode ? 0 : $urandom_range(99);
      first_episode = 1'b0;
      if (kind < 25) begin
        while (held_count < DEPTH) issue_insert(held_count);
        extra = $urandom_range(2, 6);
        repeat (extra) issue_insert(held_count + 4);
        issue_op(ACT_READ_AT, 8'(DEPTH - 1), pick_value());
        issue_op(ACT_DELETE_AT, 8'(DEPTH), pick_value());
        random_sent += 2;
      end else if (kind < 45) begin
        while (held_count > 0) issue_delete(held_count - 1);
        extra = $urandom_range(1, 3);
        repeat (extra) issue_delete(255);
      end else begin
        extra = $urandom_range(10, 30);
        repeat (extra) issue_mixed();
      end
    end
    in_ch.valid <= 1'b0;
    idle_on = 1'b1;

    // Drain outstanding results, then allow for a late stray one
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("** positional_ordered_list_store: PASSED **");
    end else begin
      $display("** positional_ordered_list_store: FAILED **");
    end
    $finish;
  end

endmodule
